>>> hw/rtl/rsl_pkg.sv
// Shared types, constants and codes of the reservoir sampler.
`default_nettype none
package rsl_pkg;
   localparam int POOL_DEPTH = 1024;
   localparam int ADDR_W     = $clog2(POOL_DEPTH);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int PAYLOAD_W  = 32;
   localparam int SLOT_W     = 10;
   localparam int SEEN_W     = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
   localparam logic [63:0] LCG_INC = 64'd1442695040888963407;
   localparam logic [63:0] SEEN_MAX = {64{1'b1}};

   localparam logic [2:0] STAT_APPENDED = 3'd0;
   localparam logic [2:0] STAT_REPLACED = 3'd1;
   localparam logic [2:0] STAT_DISCARD  = 3'd2;
   localparam logic [2:0] STAT_REFUSED  = 3'd3;
   localparam logic [2:0] STAT_READ_OK  = 3'd4;
   localparam logic [2:0] STAT_UNFILLED = 3'd5;

   localparam logic KIND_OFFER = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic REG_SEED     = 1'b0;
   localparam logic REG_CAPACITY = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [PAYLOAD_W-1:0] payload;
      logic [SLOT_W-1:0]    slot;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [SLOT_W-1:0]    where;
      logic [PAYLOAD_W-1:0] read_data;
      logic [10:0]          filled;
      logic [SEEN_W-1:0]    seen;
   } rsp_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      logic [PAYLOAD_W-1:0] data;
   } pool_wr_type;

   typedef enum logic [2:0] {
      LCG_IDLE, LCG_MUL0, LCG_MUL1, LCG_MUL2, LCG_SUM
   } lcg_state_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_OFFER, ST_READ, ST_FLOOR, ST_DRAW, ST_MOD, ST_PLACE, ST_EMIT
   } rs_state_type;
endpackage
`default_nettype wire

>>> hw/rtl/rsl_pool.sv
// Pool memory: one write port, one registered read port.
`default_nettype none
module rsl_pool (
   input  wire                        clock,
   input  rsl_pkg::pool_wr_type       wr,
   input  wire                        rd_en,
   input  wire [rsl_pkg::ADDR_W-1:0]  rd_addr,
   output logic [rsl_pkg::PAYLOAD_W-1:0] rd_data
);
   import rsl_pkg::*;

   logic [PAYLOAD_W-1:0] mem [POOL_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/rsl_div.sv
// Restoring divider, one quotient bit per cycle; only the remainder is used.
`default_nettype none
module rsl_div (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [63:0] dividend,
   input  wire  [63:0] divisor,
   output logic        done,
   output logic [63:0] remainder
);
   import rsl_pkg::*;

   logic        busy_ff, busy_in;
   logic [5:0]  count_ff, count_in;
   logic        done_ff, done_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [64:0] shifted, diff;

   always_comb begin
      shifted  = {rem_ff, quo_ff[63]};
      diff     = shifted - {1'b0, dvs_ff};
      busy_in  = busy_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         rem_in   = diff[64] ? shifted[63:0] : diff[63:0];
         quo_in   = {quo_ff[62:0], ~diff[64]};
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

>>> hw/rtl/rsl_lcg.sv
// 64-bit LCG stepped by one shared 32x32 multiplier, states MUL0 to SUM.
`default_nettype none
module rsl_lcg (
   input  wire         clock,
   input  wire         reset,
   input  wire         load,
   input  wire  [63:0] load_value,
   input  wire         start,
   output logic        done,
   output logic [63:0] value
);
   import rsl_pkg::*;

   lcg_state_type state_ff, state_in;
   logic [63:0] rng_ff, rng_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] cross_ff, cross_in;
   logic        done_ff, done_in;
   logic [31:0] op_a, op_b;
   logic [63:0] product;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LCG_IDLE: if (start) state_in = LCG_MUL0;
         LCG_MUL0: state_in = LCG_MUL1;
         LCG_MUL1: state_in = LCG_MUL2;
         LCG_MUL2: state_in = LCG_SUM;
         LCG_SUM:  state_in = LCG_IDLE;
         default:  state_in = LCG_IDLE;
      endcase
   end

   always_comb begin
      op_a = rng_ff[31:0];
      op_b = LCG_MUL[31:0];
      case (state_ff)
         LCG_MUL1: op_b = LCG_MUL[63:32];
         LCG_MUL2: op_a = rng_ff[63:32];
         default: ;
      endcase
      product  = op_a * op_b;
      prod_in  = prod_ff;
      cross_in = cross_ff;
      rng_in   = rng_ff;
      done_in  = 1'b0;
      case (state_ff)
         LCG_MUL0: prod_in  = product + LCG_INC;
         LCG_MUL1: cross_in = product[31:0];
         LCG_MUL2: cross_in = cross_ff + product[31:0];
         LCG_SUM: begin
            rng_in  = prod_ff + {cross_ff, 32'd0};
            done_in = 1'b1;
         end
         default: ;
      endcase
      if (load) rng_in = load_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LCG_IDLE;
         rng_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rng_ff   <= rng_in;
         done_ff  <= done_in;
      end
      prod_ff  <= prod_in;
      cross_ff <= cross_in;
   end

   assign done  = done_ff;
   assign value = rng_ff;
endmodule
`default_nettype wire

>>> hw/rtl/reservoir_sampler_lcg.sv
// Top level of the reservoir sampler: control, counters and register port.
//
// Uniform reservoir sampler (Algorithm R) over a 1024 x 32 pool held in one
// synchronous RAM. Each request word is either an offer (kind 0) or a slot
// read (kind 1) and yields exactly one response word. A read goes through
// the states READ and EMIT to the output register; an offer that still
// fills the pool, or that is refused because the seen count is saturated,
// goes through OFFER and EMIT. An offer past the fill phase runs the draw:
// one pass of the bit-serial divider for the rejection floor (2^64 - seen)
// mod seen, one LCG step per draw (one shared 32x32 multiplier over four
// phases), redrawn while below the floor, and a second divider pass for
// draw mod seen. req_stall is high while an item is at work; a finished
// response waits in the output register without blocking the next request.
// A slot reads as filled when its index is below the fill count, so the pool
// needs no reset sweep. Registers: seed at byte 0 (64 bits, a write also
// reloads the generator), capacity at byte 8 (11 bits, 0 acts as 1, above
// 1024 acts as 1024). Write them only while idle.
`default_nettype none
module reservoir_sampler_lcg (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  rsl_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output rsl_pkg::rsp_type             rsp_data,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire [rsl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire [rsl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rsl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                         csr_pready
);
   import rsl_pkg::*;

   rs_state_type state_ff, state_in;

   req_type            item_ff, item_in;
   rsp_type            res_ff, res_in;
   rsp_type            out_ff, out_in;
   logic               out_valid_ff, out_valid_in;
   logic [SEEN_W-1:0]  seen_ff, seen_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [63:0]        floor_ff, floor_in;
   logic [63:0]        j_ff, j_in;
   logic [63:0]        seed_ff, seed_in;
   logic [10:0]        capacity_ff, capacity_in;

   logic               accept, out_free, csr_wr;
   logic [10:0]        cap;
   logic [SEEN_W-1:0]  seen_next;
   logic               div_start, div_done, lcg_start, lcg_done;
   logic [63:0]        div_dividend, div_divisor, div_rem, lcg_value;
   logic [PAYLOAD_W-1:0] rd_data;
   pool_wr_type        pool_wr;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign seen_next = seen_ff + 64'd1;

   // clamp capacity into 1 .. POOL_DEPTH
   always_comb begin
      if (capacity_ff == '0) begin
         cap = 11'd1;
      end else if (capacity_ff > 11'(POOL_DEPTH)) begin
         cap = 11'(POOL_DEPTH);
      end else begin
         cap = capacity_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = (req_data.kind == KIND_READ) ? ST_READ : ST_OFFER;
         end
         ST_OFFER: begin
            if (seen_ff == SEEN_MAX || {53'd0, fill_ff} < {53'd0, cap}) begin
               state_in = ST_EMIT;
            end else if (seen_next <= 64'd1) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_FLOOR;
            end
         end
         ST_READ:  state_in = ST_EMIT;
         ST_FLOOR: if (div_done) state_in = ST_DRAW;
         ST_DRAW:  if (lcg_done && lcg_value >= floor_ff) state_in = ST_MOD;
         ST_MOD:   if (div_done) state_in = ST_PLACE;
         ST_PLACE: state_in = ST_EMIT;
         ST_EMIT:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // unit strobes and pool access
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      div_start    = 1'b0;
      div_dividend = lcg_value;
      div_divisor  = seen_ff;
      lcg_start    = 1'b0;
      pool_wr.en   = 1'b0;
      pool_wr.addr = fill_ff[ADDR_W-1:0];
      pool_wr.data = item_ff.payload;
      case (state_ff)
         ST_OFFER: begin
            if (seen_ff != SEEN_MAX) begin
               if ({53'd0, fill_ff} < {53'd0, cap}) begin
                  pool_wr.en = 1'b1;
               end else if (seen_next > 64'd1) begin
                  // floor = (2^64 - bound) mod bound
                  div_start    = 1'b1;
                  div_dividend = 64'd0 - seen_next;
                  div_divisor  = seen_next;
               end
            end
         end
         ST_FLOOR: lcg_start = div_done;
         ST_DRAW: begin
            if (lcg_done) begin
               if (lcg_value < floor_ff) begin
                  lcg_start = 1'b1;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_PLACE: begin
            pool_wr.addr = j_ff[ADDR_W-1:0];
            pool_wr.en   = (j_ff < {53'd0, cap});
         end
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      item_in      = item_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      seen_in      = seen_ff;
      fill_in      = fill_ff;
      floor_in     = floor_ff;
      j_in         = j_ff;
      seed_in      = seed_ff;
      capacity_in  = capacity_ff;

      if (accept) item_in = req_data;

      case (state_ff)
         ST_OFFER: begin
            res_in.where     = '0;
            res_in.read_data = '0;
            res_in.filled    = fill_ff;
            res_in.seen      = seen_ff;
            if (seen_ff == SEEN_MAX) begin
               res_in.status = STAT_REFUSED;
            end else begin
               seen_in          = seen_next;
               res_in.seen      = seen_next;
               if ({53'd0, fill_ff} < {53'd0, cap}) begin
                  res_in.status = STAT_APPENDED;
                  res_in.where  = fill_ff[SLOT_W-1:0];
                  fill_in       = fill_ff + 11'd1;
                  res_in.filled = fill_ff + 11'd1;
               end else begin
                  j_in = '0;
               end
            end
         end
         ST_READ: begin
            res_in.where  = item_ff.slot;
            res_in.filled = fill_ff;
            res_in.seen   = seen_ff;
            if ({1'b0, item_ff.slot} < fill_ff) begin
               res_in.status    = STAT_READ_OK;
               res_in.read_data = rd_data;
            end else begin
               res_in.status    = STAT_UNFILLED;
               res_in.read_data = '0;
            end
         end
         ST_FLOOR: if (div_done) floor_in = div_rem;
         ST_MOD:   if (div_done) j_in = div_rem;
         ST_PLACE: begin
            if (j_ff < {53'd0, cap}) begin
               res_in.status = STAT_REPLACED;
               res_in.where  = j_ff[SLOT_W-1:0];
            end else begin
               res_in.status = STAT_DISCARD;
               res_in.where  = '0;
            end
         end
         default: ;
      endcase

      // drop the shown word once taken, load the next one when free
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (state_ff == ST_EMIT && out_free) begin
         out_in       = res_ff;
         out_valid_in = 1'b1;
      end

      if (csr_wr) begin
         if (csr_paddr[3] == REG_SEED) begin
            seed_in = csr_pwdata;
         end else begin
            capacity_in = csr_pwdata[10:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         seen_ff      <= '0;
         fill_ff      <= '0;
         seed_ff      <= '0;
         capacity_ff  <= 11'd1024;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         seen_ff      <= seen_in;
         fill_ff      <= fill_in;
         seed_ff      <= seed_in;
         capacity_ff  <= capacity_in;
      end
      item_ff  <= item_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
      floor_ff <= floor_in;
      j_ff     <= j_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == REG_CAPACITY) ? {53'd0, capacity_ff} : seed_ff;

   rsl_pool u_pool (
      .clock   (clock),
      .wr      (pool_wr),
      .rd_en   (accept && req_data.kind == KIND_READ),
      .rd_addr (req_data.slot[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   rsl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   rsl_lcg u_lcg (
      .clock      (clock),
      .reset      (reset),
      .load       (csr_wr && csr_paddr[3] == REG_SEED),
      .load_value (csr_pwdata),
      .start      (lcg_start),
      .done       (lcg_done),
      .value      (lcg_value)
   );
endmodule
`default_nettype wire

>>> hw/rtl/rsl_checker.sv
// Port-level checks of the reservoir sampler and their bind.
`default_nettype none
module rsl_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            rsp_valid,
   input wire                            rsp_stall,
   input rsl_pkg::rsp_type               rsp_data
);
   import rsl_pkg::*;

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed under stall");

   // an append lands at the slot just below the new fill count
   a_append_where: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_APPENDED |->
         rsp_data.where == SLOT_W'(rsp_data.filled - 11'd1))
      else $error("append slot does not match fill count");

   // a replacement targets a filled slot
   a_replace_filled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_REPLACED |->
         {1'b0, rsp_data.where} < rsp_data.filled)
      else $error("replacement outside filled slots");

   // an unfilled read returns zero data
   a_unfilled_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_UNFILLED |-> rsp_data.read_data == '0)
      else $error("unfilled read returned data");
endmodule

bind reservoir_sampler_lcg rsl_checker u_rsl_checker (.*);
`default_nettype wire

>>> tb/reservoir_sampler_lcg_tb.sv
// Self-checking testbench of the reservoir sampler: predictor, drivers and checks.
`default_nettype none
module reservoir_sampler_lcg_tb;
   import rsl_pkg::*;

   // Predictor of the sampler. Track the pool, the counts and the generator,
   // and queue one expected response word per accepted request word.
   class pool_tracker;
      logic [PAYLOAD_W-1:0] pool [POOL_DEPTH];
      int unsigned          fill;
      logic [63:0]          seen;
      logic [63:0]          rng;
      logic [10:0]          cap_reg;
      rsp_type              expected_words[$];
      int unsigned          errors, n_append, n_replace, n_discard, n_read;

      function new();
         fill = 0; seen = '0; rng = '0; cap_reg = 11'd1024;
         errors = 0; n_append = 0; n_replace = 0; n_discard = 0; n_read = 0;
      endfunction

      function void load_seed(logic [63:0] v);
         rng = v;
      endfunction

      function void load_capacity(logic [10:0] v);
         cap_reg = v;
      endfunction

      // Unbiased draw below bound: redraw while under (2^64 - bound) mod bound.
      function logic [63:0] draw_index(logic [63:0] bound);
         logic [63:0] floor_v;
         if (bound <= 64'd1) return '0;
         floor_v = (64'd0 - bound) % bound;
         do begin
            rng = rng * LCG_MUL + LCG_INC;
         end while (rng < floor_v);
         return rng % bound;
      endfunction

      function void note_request(req_type w);
         rsp_type     e;
         int unsigned c;
         logic [63:0] j;
         e = '0;
         if (w.kind == KIND_OFFER) begin
            if (seen == SEEN_MAX) begin
               e.status = STAT_REFUSED;
            end else begin
               // capacity zero acts as one, anything above the pool saturates
               c = (cap_reg == 0) ? 1 : ((cap_reg > POOL_DEPTH) ? POOL_DEPTH : cap_reg);
               seen++;
               if (fill < c) begin
                  e.where = SLOT_W'(fill);
                  pool[fill] = w.payload;
                  fill++;
                  e.status = STAT_APPENDED;
                  n_append++;
               end else begin
                  j = draw_index(seen);
                  if (j < c) begin
                     pool[j] = w.payload;
                     e.where = SLOT_W'(j);
                     e.status = STAT_REPLACED;
                     n_replace++;
                  end else begin
                     e.status = STAT_DISCARD;
                     n_discard++;
                  end
               end
            end
         end else begin
            e.where = w.slot;
            n_read++;
            // slots below the fill count are exactly the written ones
            if (w.slot < fill) begin
               e.read_data = pool[w.slot];
               e.status = STAT_READ_OK;
            end else begin
               e.status = STAT_UNFILLED;
            end
         end
         e.filled = 11'(fill);
         e.seen = seen;
         expected_words.push_back(e);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
         errors++;
      endtask

      task check_result(rsp_type g);
         rsp_type e;
         if (expected_words.size() == 0) begin
            report("unexpected response word, status", g.status, 0);
            return;
         end
         e = expected_words.pop_front();
         if (g.status != e.status) report("status", g.status, e.status);
         if (g.where != e.where) report("where", g.where, e.where);
         if (g.read_data != e.read_data) report("read_data", g.read_data, e.read_data);
         if (g.filled != e.filled) report("filled", g.filled, e.filled);
         if (g.seen != e.seen) report("seen", g.seen, e.seen);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pool_tracker model = new();
   int          stall_pct = 0;
   int          stall_hold = 0;
   int          gap_pct = 0;
   int          idle_cycles = 0;
   localparam int IDLE_LIMIT = 5000;

   reservoir_sampler_lcg dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stall, now and then a long hold, none when stall_pct is 0.
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_stall <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(99) < 2) begin
         stall_hold <= $urandom_range(60, 20);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // Check each accepted response word against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) model.check_result(rsp_data);
   end

   // Watchdog: end the run after too many cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [CSR_ADDR_W-1:0] reg_addr(logic idx);
      return CSR_ADDR_W'(8 * int'(idx));
   endfunction

   // Write one register (setup, then access), then read it back.
   task automatic write_reg(logic idx, logic [63:0] value);
      logic [63:0] mask;
      mask = (idx == REG_CAPACITY) ? 64'h7FF : '1;
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
      csr_paddr = reg_addr(idx); csr_pwdata = value;
      @(negedge clock) csr_penable = 1'b1;
      @(negedge clock) begin
         csr_pwrite = 1'b0; csr_penable = 1'b0;
      end
      @(negedge clock) csr_penable = 1'b1;
      @(posedge clock);
      if ((csr_prdata & mask) != (value & mask))
         model.report("register readback", csr_prdata & mask, value & mask);
      @(negedge clock) begin
         csr_psel = 1'b0; csr_penable = 1'b0;
      end
      if (idx == REG_SEED) model.load_seed(value);
      else model.load_capacity(value[10:0]);
   endtask

   // Hold the sender until every expected word has come back.
   task automatic drain();
      req_valid = 1'b0;
      while (model.expected_words.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Present one word, hold it until accepted, then maybe leave a gap.
   task automatic send_word(req_type w);
      int gap;
      req_data = w;
      req_valid = 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      model.note_request(w);
      @(negedge clock);
      gap = 0;
      if ($urandom_range(99) < gap_pct)
         gap = ($urandom_range(19) == 0) ? $urandom_range(60, 15) : $urandom_range(3, 1);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic offer(logic [PAYLOAD_W-1:0] p);
      req_type w;
      w = '0; w.kind = KIND_OFFER; w.payload = p; w.slot = SLOT_W'($urandom);
      send_word(w);
   endtask

   task automatic read_slot(logic [SLOT_W-1:0] s);
      req_type w;
      w = '0; w.kind = KIND_READ; w.slot = s; w.payload = $urandom;
      send_word(w);
   endtask

   // Random word; reads only touch slots already written.
   task automatic random_word(int offer_pct);
      logic [PAYLOAD_W-1:0] p;
      if (model.fill == 0 || $urandom_range(99) < offer_pct) begin
         case ($urandom_range(15))
            0: p = '0;
            1: p = '1;
            default: p = $urandom;
         endcase
         offer(p);
      end else begin
         read_slot(SLOT_W'($urandom_range(model.fill - 1)));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // Directed: capacity zero acts as one; later offers replace slot 0 or are dropped.
      write_reg(REG_SEED, 64'd0);
      write_reg(REG_CAPACITY, 64'd0);
      offer('0);
      read_slot(0);
      offer('1);
      offer(32'hA5A5_5A5A);
      offer(32'h0000_0001);
      read_slot(0);
      drain();
      write_reg(REG_CAPACITY, 64'd1);
      offer(32'h8000_0000);
      offer(32'h7FFF_FFFF);
      read_slot(0);
      drain();
      // Raise capacity: appends resume; seed all ones.
      write_reg(REG_SEED, '1);
      write_reg(REG_CAPACITY, 64'd4);
      repeat (6) offer($urandom);
      for (int s = 0; s < 4; s++) read_slot(SLOT_W'(s));
      drain();

      // Random, small pool with frequent discards; receiver stalls.
      stall_pct = 30; gap_pct = 30;
      write_reg(REG_SEED, {$urandom, $urandom});
      write_reg(REG_CAPACITY, 64'd16);
      repeat (50) random_word(70);
      drain();

      // Capacity above the pool saturates: fill all 1024 slots, back to back.
      stall_pct = 0; gap_pct = 0;
      write_reg(REG_CAPACITY, 64'h7FF);
      while (model.fill < POOL_DEPTH) random_word(98);
      stall_pct = 25; gap_pct = 40;
      repeat (60) random_word(50);
      read_slot('1);
      drain();

      // Capacity far below the fill count: replacements hit low slots only.
      write_reg(REG_SEED, {$urandom, $urandom});
      write_reg(REG_CAPACITY, 64'd1024);
      write_reg(REG_CAPACITY, 64'd2);
      repeat (40) random_word(60);
      drain();

      repeat (20) @(posedge clock);
      $display("covered %0d appends, %0d replacements, %0d discards, %0d slot reads",
               model.n_append, model.n_replace, model.n_discard, model.n_read);
      $display("capacities 0 to 2047, seeds 0, all ones and random; final seen count %0d",
               model.seen);
      if (model.errors == 0 && model.expected_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
